// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CHECK_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define CHECK_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hdl/cesu_pkg.sv =====
`default_nettype none

package cesu_pkg;

    // Queue between classifier and byte serializer
    localparam int QueueDepthDefault = 2;

    // Longest byte sequence for one character (surrogate pair, 3 bytes each)
    localparam int MaxBytes = 6;
    localparam int IdxW     = $clog2(MaxBytes);

    // Code point limits
    localparam logic [31:0] CpMax   = 32'h0010_FFFF;
    localparam logic [31:0] BmpMax  = 32'h0000_FFFF;
    localparam logic [20:0] SuppOfs = 21'h01_0000;

    // Surrogate prefixes (upper six bits of each half)
    localparam logic [5:0] SurHiPfx = 6'b110110;  // 0xD800
    localparam logic [5:0] SurLoPfx = 6'b110111;  // 0xDC00

    // UTF-8 style range limits and lead bytes
    localparam logic [15:0] Lim1Byte = 16'h0080;
    localparam logic [15:0] Lim2Byte = 16'h0800;
    localparam logic [7:0]  Lead2    = 8'hC0;
    localparam logic [7:0]  Lead3    = 8'hE0;
    localparam logic [7:0]  ContPfx  = 8'h80;

    typedef enum logic {
        MODE_CESU8   = 1'b0,
        MODE_UTF16BE = 1'b1
    } enc_mode_t;

    // One classified character: its bytes, index of the final byte, flags
    typedef struct packed {
        logic [MaxBytes-1:0][7:0] bytes;
        logic [IdxW-1:0]          last_idx;
        logic                     last_char;
        logic                     err;
    } cesu_desc_t;

endpackage

`default_nettype wire

// ===== hdl/cesu_front.sv =====
`default_nettype none

module cesu_front
    import cesu_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // config write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,
    // input beats
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] code_point
    input  wire logic        s_tlast,   // last_char
    // queue write side
    output logic             push_valid,
    input  wire logic        push_ready,
    output cesu_desc_t       push_desc
);

    enc_mode_t mode_reg, mode_next;

    logic        is_err;
    logic        is_supp;
    logic [20:0] sub_val;
    logic [19:0] ofs_val;
    logic [15:0] sur_hi;
    logic [15:0] sur_lo;
    logic [15:0] unit;

    // Mode register, always ready for a write
    assign cfg_ready = 1'b1;

    always_comb begin
        mode_next = mode_reg;
        if (cfg_valid) begin
            mode_next = enc_mode_t'(cfg_data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_CESU8;
        end else begin
            mode_reg <= mode_next;
        end
    end

    // Handshake straight through to the queue
    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;

    // Range checks and surrogate split
    assign is_err  = s_tdata > CpMax;
    assign is_supp = s_tdata > BmpMax;
    assign sub_val = s_tdata[20:0] - SuppOfs;
    assign ofs_val = sub_val[19:0];
    assign sur_hi  = {SurHiPfx, ofs_val[19:10]};
    assign sur_lo  = {SurLoPfx, ofs_val[9:0]};
    assign unit    = s_tdata[15:0];

    // Classify and lay out the byte sequence
    always_comb begin
        push_desc           = '0;
        push_desc.last_char = s_tlast;
        if (is_err) begin
            push_desc.err      = 1'b1;
            push_desc.last_idx = IdxW'(0);
        end else if (is_supp) begin
            if (mode_reg == MODE_UTF16BE) begin
                push_desc.bytes[0] = sur_hi[15:8];
                push_desc.bytes[1] = sur_hi[7:0];
                push_desc.bytes[2] = sur_lo[15:8];
                push_desc.bytes[3] = sur_lo[7:0];
                push_desc.last_idx = IdxW'(3);
            end else begin
                push_desc.bytes[0] = Lead3   | {4'h0, sur_hi[15:12]};
                push_desc.bytes[1] = ContPfx | {2'b00, sur_hi[11:6]};
                push_desc.bytes[2] = ContPfx | {2'b00, sur_hi[5:0]};
                push_desc.bytes[3] = Lead3   | {4'h0, sur_lo[15:12]};
                push_desc.bytes[4] = ContPfx | {2'b00, sur_lo[11:6]};
                push_desc.bytes[5] = ContPfx | {2'b00, sur_lo[5:0]};
                push_desc.last_idx = IdxW'(5);
            end
        end else if (mode_reg == MODE_UTF16BE) begin
            push_desc.bytes[0] = unit[15:8];
            push_desc.bytes[1] = unit[7:0];
            push_desc.last_idx = IdxW'(1);
        end else if (unit < Lim1Byte) begin
            push_desc.bytes[0] = unit[7:0];
            push_desc.last_idx = IdxW'(0);
        end else if (unit < Lim2Byte) begin
            push_desc.bytes[0] = Lead2   | {3'b000, unit[10:6]};
            push_desc.bytes[1] = ContPfx | {2'b00, unit[5:0]};
            push_desc.last_idx = IdxW'(1);
        end else begin
            push_desc.bytes[0] = Lead3   | {4'h0, unit[15:12]};
            push_desc.bytes[1] = ContPfx | {2'b00, unit[11:6]};
            push_desc.bytes[2] = ContPfx | {2'b00, unit[5:0]};
            push_desc.last_idx = IdxW'(2);
        end
    end

endmodule

`default_nettype wire

// ===== hdl/cesu_queue.sv =====
`default_nettype none

module cesu_queue
    import cesu_pkg::*;
#(
    parameter int DEPTH = QueueDepthDefault
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push_valid,
    output logic            push_ready,
    input  wire cesu_desc_t push_desc,
    output logic            pop_valid,
    input  wire logic       pop_ready,
    output cesu_desc_t      pop_desc
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    cesu_desc_t            entries_reg [DEPTH];
    logic [PtrW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]       count_reg, count_next;
    logic                  do_push;
    logic                  do_pop;

    assign push_ready = count_reg != CntW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_desc   = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/cesu_back.sv =====
`default_nettype none
`include "assert_macros.svh"

module cesu_back
    import cesu_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // queue read side
    input  wire logic       pop_valid,
    output logic            pop_ready,
    input  wire cesu_desc_t pop_desc,
    // output beats
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tlast,   // string_last
    output logic [1:0]      m_tuser    // [0] char_last, [1] error
);

    logic            cur_valid_reg, cur_valid_next;
    cesu_desc_t      cur_reg, cur_next;
    logic [IdxW-1:0] idx_reg, idx_next;

    logic            out_valid_reg, out_valid_next;
    logic [7:0]      out_byte_reg, out_byte_next;
    logic            out_clast_reg, out_clast_next;
    logic            out_slast_reg, out_slast_next;
    logic            out_err_reg, out_err_next;

    logic            advance;
    logic            emit;
    logic            at_end;
    logic            load;

    assign advance   = !out_valid_reg || m_tready;
    assign emit      = advance && cur_valid_reg;
    assign at_end    = idx_reg == cur_reg.last_idx;
    assign load      = !cur_valid_reg || (emit && at_end);
    assign pop_ready = load;

    // Serializer: one byte of the current character per beat
    always_comb begin
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_clast_next = out_clast_reg;
        out_slast_next = out_slast_reg;
        out_err_next   = out_err_reg;

        if (emit) begin
            out_valid_next = 1'b1;
            out_byte_next  = cur_reg.bytes[idx_reg];
            out_clast_next = at_end;
            out_slast_next = at_end && cur_reg.last_char;
            out_err_next   = cur_reg.err;
            idx_next       = idx_reg + 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end

        if (load) begin
            cur_valid_next = pop_valid;
            cur_next       = pop_desc;
            idx_next       = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg       <= cur_next;
        out_byte_reg  <= out_byte_next;
        out_clast_reg <= out_clast_next;
        out_slast_reg <= out_slast_next;
        out_err_reg   <= out_err_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_byte_reg;
    assign m_tlast    = out_slast_reg;
    assign m_tuser[0] = out_clast_reg;
    assign m_tuser[1] = out_err_reg;

    // Checks
    `CHECK_IMPLY(a_slast_on_clast, aclk, aresetn, m_tvalid && m_tlast, m_tuser[0])
    `CHECK_IMPLY(a_err_single_zero, aclk, aresetn, m_tvalid && m_tuser[1],
                 m_tuser[0] && (m_tdata == 8'h00))
    `CHECK_IMPLY(a_idx_in_range, aclk, aresetn, cur_valid_reg, idx_reg <= cur_reg.last_idx)
    `CHECK_NEXT(a_char_held, aclk, aresetn, cur_valid_reg && !(emit && at_end),
                cur_valid_reg)

endmodule

`default_nettype wire

// ===== hdl/char_encoder_cesu8_utf16be_top.sv =====
// Code point to byte stream encoder, CESU-8 or UTF-16BE.
// Input channel (s_): one beat per character, s_tdata = 32-bit code point,
//   s_tlast = final character of the string.
// Output channel (m_): one beat per encoded byte, m_tdata = byte,
//   m_tuser[0] = final byte of the character, m_tuser[1] = code point above
//   0x10FFFF (single zero byte), m_tlast = final byte of the final character.
// Config channel (cfg_): 1-bit mode, 0 = CESU-8, 1 = UTF-16BE; always ready.
//   Write only while no characters are in flight.
// Path: a character goes into the queue, then into the serializer's
//   current-character register, and its bytes leave by the output register.
// Throughput: one output byte per cycle while m_tready is high; a character
//   is 1 to 6 bytes (6 for a supplementary character in CESU-8 mode, 4 in
//   UTF-16BE mode); the serializer's one-byte output register sets this.
// The classifier and serializer are parted by a QUEUE_DEPTH entry queue, so
//   new characters are taken while earlier ones are still being sent.
// Reset (aresetn low, synchronous) empties the queue and output register and
//   selects CESU-8 mode. A stall on m_tready holds the output beat; input is
//   taken until the queue fills.
`default_nettype none

module char_encoder_cesu8_utf16be_top
    import cesu_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepthDefault
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,   // encoding_mode
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,    // [31:0] code_point
    input  wire logic        s_tlast,    // last_char
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,    // [7:0] out_byte
    output logic             m_tlast,    // string_last
    output logic [1:0]       m_tuser     // [0] char_last, [1] error
);

    logic       push_valid;
    logic       push_ready;
    cesu_desc_t push_desc;
    logic       pop_valid;
    logic       pop_ready;
    cesu_desc_t pop_desc;

    cesu_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc)
    );

    cesu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_desc   (pop_desc)
    );

    cesu_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_desc  (pop_desc),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

// ===== sim/tb_char_encoder_cesu8_utf16be_top.sv =====
`timescale 1ns / 100ps

module tb_char_encoder_cesu8_utf16be_top;
    import cesu_pkg::*;

    localparam logic [31:0] TOP_CODE_POINT = 32'h0010_FFFF;
    localparam logic [31:0] TOP_BMP        = 32'h0000_FFFF;
    localparam int          MAX_REPORTS    = 10;

    // Range ends of every byte-count class, lone surrogates and bad values
    localparam logic [31:0] BOUNDARY_CPS [12] = '{
        32'h0000_0000, 32'h0000_007F, 32'h0000_0080, 32'h0000_07FF,
        32'h0000_0800, 32'h0000_D800, 32'h0000_DFFF, 32'h0000_FFFF,
        32'h0001_0000, 32'h0010_FFFF, 32'h0011_0000, 32'hFFFF_FFFF
    };

    // One encoded byte as seen on the output channel
    typedef struct packed {
        logic [7:0] data;
        logic       char_end;
        logic       str_end;
        logic       err;
    } enc_byte_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;

    enc_byte_t   byte_expect [$];
    enc_mode_t   cur_mode = MODE_CESU8;
    int          src_gap_pct = 0;
    int          sink_stall_pct = 0;
    int          mismatches = 0;
    int          bytes_checked = 0;
    int          chars_sent = 0;
    int          bad_chars = 0;
    int          supp_chars = 0;
    int          chars_per_mode [2] = '{0, 0};

    char_encoder_cesu8_utf16be_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Encoder prediction: appends the bytes of one character
    function automatic void push_byte(logic [7:0] b);
        byte_expect.push_back('{data: b, char_end: 1'b0, str_end: 1'b0, err: 1'b0});
    endfunction

    function automatic void push_unit(logic [15:0] u);
        if (cur_mode == MODE_UTF16BE) begin
            push_byte(u[15:8]);
            push_byte(u[7:0]);
        end else if (u < 16'h0080) begin
            push_byte(u[7:0]);
        end else if (u < 16'h0800) begin
            push_byte({3'b110, u[10:6]});
            push_byte({2'b10, u[5:0]});
        end else begin
            push_byte({4'b1110, u[15:12]});
            push_byte({2'b10, u[11:6]});
            push_byte({2'b10, u[5:0]});
        end
    endfunction

    function automatic void encode_char(logic [31:0] cp, logic last);
        logic [31:0] ofs;
        enc_byte_t   tail;
        chars_sent++;
        chars_per_mode[cur_mode]++;
        if (cp > TOP_CODE_POINT) begin
            bad_chars++;
            byte_expect.push_back('{data: 8'h00, char_end: 1'b1, str_end: last, err: 1'b1});
        end else begin
            if (cp > TOP_BMP) begin
                // surrogate pair from the 20-bit offset
                supp_chars++;
                ofs = cp - 32'h0001_0000;
                push_unit({6'b110110, ofs[19:10]});
                push_unit({6'b110111, ofs[9:0]});
            end else begin
                push_unit(cp[15:0]);
            end
            tail = byte_expect.pop_back();
            tail.char_end = 1'b1;
            tail.str_end = last;
            byte_expect.push_back(tail);
        end
    endfunction

    // Output side: random stalls and per-beat check
    always @(posedge aclk) begin
        enc_byte_t got;
        enc_byte_t want;
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
        if (aresetn && m_tvalid && m_tready) begin
            got = '{data: m_tdata, char_end: m_tuser[0], str_end: m_tlast, err: m_tuser[1]};
            if (byte_expect.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] unexpected beat: byte %02h char_last %b last %b err %b",
                             $realtime, got.data, got.char_end, got.str_end, got.err);
            end else begin
                want = byte_expect.pop_front();
                bytes_checked++;
                if (got.data !== want.data || got.char_end !== want.char_end ||
                    got.str_end !== want.str_end || got.err !== want.err) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"[%0t] beat mismatch: exp byte %02h cl %b sl %b err %b, ",
                                  "got byte %02h cl %b sl %b err %b"}, $realtime,
                                 want.data, want.char_end, want.str_end, want.err,
                                 got.data, got.char_end, got.str_end, got.err);
                end
            end
        end
    end

    // Input side: one character beat, with random idle cycles ahead of it
    task automatic send_char(input logic [31:0] cp, input logic last);
        while ($urandom_range(99) < src_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= cp;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        encode_char(cp, last);
    endtask

    // Hold input off until every predicted byte has come out
    task automatic drain_output();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (byte_expect.size() != 0) @(posedge aclk);
    endtask

    // Mode write, only with the block empty
    task automatic write_mode(input enc_mode_t mode);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        cur_mode = mode;
    endtask

    // Weighted pick over the byte-count classes, surrogates and bad values
    function automatic logic [31:0] pick_code_point();
        case ($urandom_range(9))
            0, 1:    return $urandom_range(32'h7F, 32'h0);
            2:       return $urandom_range(32'h7FF, 32'h80);
            3, 4:    return $urandom_range(32'hFFFF, 32'h800);
            5:       return $urandom_range(32'hDFFF, 32'hD800);
            6, 7:    return $urandom_range(32'h10_FFFF, 32'h1_0000);
            8:       return $urandom_range(32'hFFFF_FFFF, 32'h11_0000);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_boundaries(input enc_mode_t mode);
        write_mode(mode);
        foreach (BOUNDARY_CPS[i])
            send_char(BOUNDARY_CPS[i], (i % 3 == 2) || (i == 11));
        drain_output();
    endtask

    // Random strings in both modes under one idle profile; the mode
    // write in the middle doubles as a full pause of the sender
    task automatic test_random_phase(input int gap_pct, input int stall_pct,
                                     input enc_mode_t first_mode, input int count);
        src_gap_pct = gap_pct;
        sink_stall_pct = stall_pct;
        write_mode(first_mode);
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) begin
                drain_output();
                write_mode(first_mode == MODE_CESU8 ? MODE_UTF16BE : MODE_CESU8);
            end
            send_char(pick_code_point(), $urandom_range(3) == 0);
        end
        drain_output();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_gap_pct = 6;
        sink_stall_pct = 73;
        test_boundaries(MODE_CESU8);
        test_boundaries(MODE_UTF16BE);

        test_random_phase(6, 73, MODE_UTF16BE, 140);
        test_random_phase(73, 6, MODE_CESU8, 140);
        test_random_phase(0, 0, MODE_UTF16BE, 140);

        // settle, so a stray beat after the last one is still caught
        repeat (20) @(posedge aclk);

        $display("Sent %0d characters (%0d CESU-8, %0d UTF-16BE; %0d supplementary, %0d invalid)",
                 chars_sent, chars_per_mode[MODE_CESU8], chars_per_mode[MODE_UTF16BE],
                 supp_chars, bad_chars);
        $display("Checked %0d output bytes under three idle/stall profiles, %0d mismatches",
                 bytes_checked, mismatches);
        if (mismatches == 0 && byte_expect.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("Timeout with %0d bytes still expected", byte_expect.size());
        $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/cesu_pkg.sv
hdl/cesu_front.sv
hdl/cesu_queue.sv
hdl/cesu_back.sv
hdl/char_encoder_cesu8_utf16be_top.sv
sim/tb_char_encoder_cesu8_utf16be_top.sv
